/* rtl/hud_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hud_pkg
// shared types and codes for the hci uart packet deframer
// ----------------------------------------------------------------------------
package hud_pkg;

	// packet type bytes seen in idle
	localparam logic [7:0] TYPE_CMD   = 8'h01;
	localparam logic [7:0] TYPE_ACL   = 8'h02;
	localparam logic [7:0] TYPE_EVENT = 8'h04;
	localparam logic [7:0] TYPE_LOCAL = 8'h20;

	// header position of the length byte(s), type byte counts as 1
	localparam logic [2:0] POS_EVT_LEN    = 3'd3;
	localparam logic [2:0] POS_CMD_LEN    = 3'd4;
	localparam logic [2:0] POS_ACL_LEN_LO = 3'd4;
	localparam logic [2:0] POS_ACL_LEN_HI = 3'd5;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_CMD   = 3'd1,
		KIND_ACL   = 3'd2,
		KIND_EVENT = 3'd3,
		KIND_LOCAL = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_HEADER  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	// one tagged byte
	typedef struct packed {
		logic [7:0] byte_out;
		kind_t      packet_kind;
		logic       first_of_packet;
		logic       last_of_packet;
		logic       dropped;
	} result_t;

	function automatic kind_t kind_of_type(input logic [7:0] b);
		kind_t k;
		case (b)
			TYPE_CMD:   k = KIND_CMD;
			TYPE_ACL:   k = KIND_ACL;
			TYPE_EVENT: k = KIND_EVENT;
			TYPE_LOCAL: k = KIND_LOCAL;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

/* rtl/hud_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hud_tracker
// packet framing state and per-byte tagging
// ----------------------------------------------------------------------------
module hud_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	output hud_pkg::result_t res
);

	hud_pkg::phase_t phase_q, phase_d;
	hud_pkg::kind_t  kind_q, kind_d;
	logic [2:0]      hdr_cnt_q, hdr_cnt_d;
	logic [15:0]     remain_q, remain_d;

	logic [2:0]      pos;
	logic            len_done;
	hud_pkg::kind_t  new_kind;

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		hdr_cnt_d = hdr_cnt_q;
		remain_d  = remain_q;
		len_done  = 1'b0;
		pos       = hdr_cnt_q + 3'd1;
		new_kind  = hud_pkg::kind_of_type(rx_byte);

		res.byte_out        = rx_byte;
		res.packet_kind     = hud_pkg::KIND_NONE;
		res.first_of_packet = 1'b0;
		res.last_of_packet  = 1'b0;
		res.dropped         = 1'b0;

		unique case (phase_q)
			hud_pkg::PH_HEADER: begin
				res.packet_kind = kind_q;
				hdr_cnt_d       = pos;
				case (kind_q)
					hud_pkg::KIND_ACL: begin
						if (pos == hud_pkg::POS_ACL_LEN_LO) begin
							remain_d = {8'd0, rx_byte};
						end else if (pos == hud_pkg::POS_ACL_LEN_HI) begin
							remain_d = remain_q | {rx_byte, 8'd0};
							len_done = 1'b1;
						end
					end
					hud_pkg::KIND_EVENT: begin
						if (pos == hud_pkg::POS_EVT_LEN) begin
							remain_d = {8'd0, rx_byte};
							len_done = 1'b1;
						end
					end
					hud_pkg::KIND_CMD, hud_pkg::KIND_LOCAL: begin
						if (pos == hud_pkg::POS_CMD_LEN) begin
							remain_d = {8'd0, rx_byte};
							len_done = 1'b1;
						end
					end
					default: begin
						// corrupted kind: close out and resync
						res.packet_kind    = hud_pkg::KIND_NONE;
						res.last_of_packet = 1'b1;
						phase_d   = hud_pkg::PH_IDLE;
						kind_d    = hud_pkg::KIND_NONE;
						hdr_cnt_d = 3'd0;
						remain_d  = 16'd0;
					end
				endcase
				if (len_done) begin
					if (remain_d == 16'd0) begin
						res.last_of_packet = 1'b1;
						phase_d   = hud_pkg::PH_IDLE;
						kind_d    = hud_pkg::KIND_NONE;
						hdr_cnt_d = 3'd0;
					end else begin
						phase_d = hud_pkg::PH_PAYLOAD;
					end
				end
			end
			hud_pkg::PH_PAYLOAD: begin
				res.packet_kind = kind_q;
				if (remain_q <= 16'd1) begin
					res.last_of_packet = 1'b1;
					phase_d   = hud_pkg::PH_IDLE;
					kind_d    = hud_pkg::KIND_NONE;
					hdr_cnt_d = 3'd0;
					remain_d  = 16'd0;
				end else begin
					remain_d = remain_q - 16'd1;
				end
			end
			default: begin
				res.packet_kind = new_kind;
				if (new_kind == hud_pkg::KIND_NONE) begin
					res.dropped = 1'b1;
					phase_d   = hud_pkg::PH_IDLE;
					kind_d    = hud_pkg::KIND_NONE;
					hdr_cnt_d = 3'd0;
					remain_d  = 16'd0;
				end else begin
					res.first_of_packet = 1'b1;
					phase_d   = hud_pkg::PH_HEADER;
					kind_d    = new_kind;
					hdr_cnt_d = 3'd1;
					remain_d  = 16'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hud_pkg::PH_IDLE;
			kind_q    <= hud_pkg::KIND_NONE;
			hdr_cnt_q <= 3'd0;
			remain_q  <= 16'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			hdr_cnt_q <= hdr_cnt_d;
			remain_q  <= remain_d;
		end
	end

endmodule

/* rtl/hci_uart_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer
// delimits hci h4 packets in a received uart byte stream
// ----------------------------------------------------------------------------
// Every received byte comes out once, tagged with the kind of packet it belongs
// to and with first, last and dropped flags. One byte is taken per clock unless
// the output stalls, and a byte passes the input register, then the result
// register; the sustained rate is set by the framing state update, a single
// short step between the input register and the result register. In idle the
// byte must be a type byte (0x01 command, 0x02 acl data, 0x04 event, 0x20 local
// command); any other byte is passed with kind none and the dropped flag. The
// payload length comes from header byte 4 (command, local), byte 3 (event) or
// bytes 4 and 5 little-endian (acl), the type byte being byte 1. A zero length
// ends the packet on the length byte. A stalled output holds its result while
// the input register still takes one more byte.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic [4:0] m_tuser,   // [2:0] packet_kind, [3] first_of_packet, [4] dropped
	output logic       m_tlast    // last_of_packet
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic             valid_s2;
	hud_pkg::result_t res_s2;

	hud_pkg::result_t res;
	logic             advance;
	logic             take;

	// move the held byte to the result register when that slot frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	// input register takes a request when empty or emptying
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	hud_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.byte_out;
	assign m_tuser  = {res_s2.dropped, res_s2.first_of_packet, res_s2.packet_kind};
	assign m_tlast  = res_s2.last_of_packet;

endmodule

/* tb/hci_uart_packet_deframer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_test
// self-checking bench for the h4 deframer: byte stream in, tagged bytes out
// ----------------------------------------------------------------------------
// A directed burst covers the dropped type bytes, the vendor types and the
// zero-length command, event and acl packets. A random stream of mostly
// well-formed packets follows, with noise and cut-off packets mixed in.
// Each accepted request is run through a framing tracker that keeps its own
// copy of the deframer state and queues the tag it expects; every output beat
// is popped and compared field by field. Both sides insert random gaps, the
// sink once holds off long enough to back the block up, and the source once
// waits for the pipe to drain.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer_test;

	localparam int PERIOD      = 8;
	localparam int RESET_LEN   = 5;
	localparam int STREAM_LEN  = 850;
	localparam int DRAIN_AT    = 450;   // source waits for an empty pipe here
	localparam int HOLD_AT     = 300;   // sink holds off after this many beats
	localparam int HOLD_LEN    = 64;
	localparam int SETTLE      = 8;     // idle clocks after the last expected tag is out
	localparam int STALL_LIMIT = 1000;

	// framing tracker and store of expected tags
	class h4_frame_tracker;
		hud_pkg::phase_t  ph;
		hud_pkg::kind_t   open_kind;
		logic [2:0]       hdr_pos;
		logic [15:0]      payload_left;
		hud_pkg::result_t expected_tags[$];
		int               mismatch_count;
		int               beat_index;

		function new();
			go_idle();
			mismatch_count = 0;
			beat_index     = 0;
		endfunction

		function void go_idle();
			ph           = hud_pkg::PH_IDLE;
			open_kind    = hud_pkg::KIND_NONE;
			hdr_pos      = '0;
			payload_left = '0;
		endfunction

		task report(input string what);
			$display("mismatch at beat %0d: %s", beat_index, what);
			mismatch_count++;
		endtask

		function int pending();
			return expected_tags.size();
		endfunction

		// advance the framing state by one accepted byte and queue its tag
		function void note_request(input logic [7:0] b);
			hud_pkg::result_t tag;
			logic [2:0]       pos;
			logic             len_done;
			tag.byte_out        = b;
			tag.packet_kind     = hud_pkg::KIND_NONE;
			tag.first_of_packet = 1'b0;
			tag.last_of_packet  = 1'b0;
			tag.dropped         = 1'b0;
			len_done            = 1'b0;
			case (ph)
				hud_pkg::PH_HEADER: begin
					pos             = hdr_pos + 3'd1;
					hdr_pos         = pos;
					tag.packet_kind = open_kind;
					case (open_kind)
						hud_pkg::KIND_ACL: begin
							// little-endian 16-bit length in bytes 4 and 5
							if (pos == hud_pkg::POS_ACL_LEN_LO) begin
								payload_left = {8'h00, b};
							end else if (pos == hud_pkg::POS_ACL_LEN_HI) begin
								payload_left = {b, payload_left[7:0]};
								len_done     = 1'b1;
							end
						end
						hud_pkg::KIND_EVENT: begin
							if (pos == hud_pkg::POS_EVT_LEN) begin
								payload_left = {8'h00, b};
								len_done     = 1'b1;
							end
						end
						hud_pkg::KIND_CMD, hud_pkg::KIND_LOCAL: begin
							if (pos == hud_pkg::POS_CMD_LEN) begin
								payload_left = {8'h00, b};
								len_done     = 1'b1;
							end
						end
						default: begin
							tag.packet_kind    = hud_pkg::KIND_NONE;
							tag.last_of_packet = 1'b1;
							go_idle();
						end
					endcase
					if (len_done) begin
						// zero length closes the packet on the length byte
						if (payload_left == 16'd0) begin
							tag.last_of_packet = 1'b1;
							go_idle();
						end else begin
							ph = hud_pkg::PH_PAYLOAD;
						end
					end
				end
				hud_pkg::PH_PAYLOAD: begin
					tag.packet_kind = open_kind;
					if (payload_left <= 16'd1) begin
						tag.last_of_packet = 1'b1;
						go_idle();
					end else begin
						payload_left = payload_left - 16'd1;
					end
				end
				default: begin
					case (b)
						hud_pkg::TYPE_CMD:   tag.packet_kind = hud_pkg::KIND_CMD;
						hud_pkg::TYPE_ACL:   tag.packet_kind = hud_pkg::KIND_ACL;
						hud_pkg::TYPE_EVENT: tag.packet_kind = hud_pkg::KIND_EVENT;
						hud_pkg::TYPE_LOCAL: tag.packet_kind = hud_pkg::KIND_LOCAL;
						default:             tag.packet_kind = hud_pkg::KIND_NONE;
					endcase
					if (tag.packet_kind == hud_pkg::KIND_NONE) begin
						// unknown or vendor type byte: flagged as dropped, stay idle
						tag.dropped = 1'b1;
						go_idle();
					end else begin
						tag.first_of_packet = 1'b1;
						ph                  = hud_pkg::PH_HEADER;
						open_kind           = tag.packet_kind;
						hdr_pos             = 3'd1;
						payload_left        = '0;
					end
				end
			endcase
			expected_tags.push_back(tag);
		endfunction

		// compare one output beat with the oldest expected tag
		task check_result(input logic [7:0] data, input logic [4:0] user,
				input logic last);
			hud_pkg::result_t tag;
			if (expected_tags.size() == 0) begin
				report($sformatf("unexpected beat data %02h user %02h", data, user));
			end else begin
				tag = expected_tags.pop_front();
				if (data !== tag.byte_out)
					report($sformatf("byte_out %02h, want %02h", data, tag.byte_out));
				if (user[2:0] !== tag.packet_kind)
					report($sformatf("packet_kind %0d, want %0d", user[2:0],
						tag.packet_kind));
				if (user[3] !== tag.first_of_packet)
					report($sformatf("first_of_packet %b, want %b", user[3],
						tag.first_of_packet));
				if (user[4] !== tag.dropped)
					report($sformatf("dropped %b, want %b", user[4], tag.dropped));
				if (last !== tag.last_of_packet)
					report($sformatf("last_of_packet %b, want %b", last,
						tag.last_of_packet));
			end
			beat_index++;
		endtask
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] byte_out
	logic [4:0] m_tuser;            // [2:0] packet_kind, [3] first_of_packet, [4] dropped
	logic       m_tlast;            // last_of_packet

	h4_frame_tracker tracker;
	int              sent_count   = 0;
	int              stall_cycles = 0;
	logic            drained      = 1'b0;
	logic            src_calm     = 1'b0;
	logic [7:0]      rx_plan[$];

	always #(PERIOD / 2) clk = ~clk;

	hci_uart_packet_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// watchdog: ends the run if no request moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one byte and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		// calm stretches with no gaps, otherwise a random idle gap before each request
		if ($urandom_range(0, 63) == 0)
			src_calm = ~src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_request(b);
		sent_count++;
	endtask

	// append one random packet, a cut-off packet or a few noise bytes
	task automatic plan_packet();
		int         pick;
		int         total;
		int         keep;
		logic [7:0] type_byte;
		logic [7:0] len_lo;
		logic [7:0] len_hi;
		logic [7:0] frame[$];
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// noise, may itself start a packet
			repeat ($urandom_range(1, 4)) rx_plan.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0:       type_byte = hud_pkg::TYPE_CMD;
				1:       type_byte = hud_pkg::TYPE_ACL;
				2:       type_byte = hud_pkg::TYPE_EVENT;
				default: type_byte = hud_pkg::TYPE_LOCAL;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 2)
				len_lo = 8'($urandom_range(64, 255));
			else if (pick < 20)
				len_lo = 8'h00;
			else
				len_lo = 8'($urandom_range(1, 12));
			// a long acl packet now and then exercises the high length byte
			len_hi = ($urandom_range(0, 19) == 0) ? 8'h01 : 8'h00;
			if (len_hi != 8'h00)
				len_lo = 8'($urandom_range(0, 8));
			frame.push_back(type_byte);
			if (type_byte == hud_pkg::TYPE_EVENT) begin
				frame.push_back(8'($urandom_range(0, 255)));
				frame.push_back(len_lo);
				total = int'(len_lo);
			end else begin
				frame.push_back(8'($urandom_range(0, 255)));
				frame.push_back(8'($urandom_range(0, 255)));
				frame.push_back(len_lo);
				total = int'(len_lo);
				if (type_byte == hud_pkg::TYPE_ACL) begin
					frame.push_back(len_hi);
					total = int'({len_hi, len_lo});
				end
			end
			repeat (total) frame.push_back(8'($urandom_range(0, 255)));
			// some packets are broken off early
			keep = ($urandom_range(0, 99) < 8) ? $urandom_range(1, frame.size()) :
				frame.size();
			for (int i = 0; i < keep; i++)
				rx_plan.push_back(frame[i]);
		end
	endtask

	// sink: random back-pressure, one long hold-off to fill the block
	initial begin
		int   gap;
		logic held;
		logic snk_calm;
		held     = 1'b0;
		snk_calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				snk_calm = ~snk_calm;
			gap = snk_calm ? 0 : $urandom_range(0, 3);
			if (!held && tracker.beat_index >= HOLD_AT) begin
				gap  = HOLD_LEN;
				held = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	// source: reset, directed burst, random stream, drain and verdict
	initial begin
		logic [7:0] directed[$];
		logic [7:0] b;
		tracker = new();
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			8'h00, 8'hFF, 8'h11, 8'h12,                            // unknown and vendor types
			hud_pkg::TYPE_CMD, 8'h03, 8'h0C, 8'h00,                // command, zero length
			hud_pkg::TYPE_EVENT, 8'h0E, 8'h00,                     // event, zero length
			hud_pkg::TYPE_LOCAL, 8'h55, 8'hAA, 8'h01, 8'h7F,       // local command, one byte
			hud_pkg::TYPE_ACL, 8'h01, 8'h20, 8'h00, 8'h00,         // acl, zero length
			hud_pkg::TYPE_ACL, 8'h02, 8'h20, 8'h01, 8'h00, 8'h80   // acl, one byte
		};
		foreach (directed[i])
			send_byte(directed[i]);

		while (sent_count < STREAM_LEN) begin
			if (rx_plan.size() == 0)
				plan_packet();
			b = rx_plan.pop_front();
			// once mid-stream, let every expected tag come out first
			if (!drained && sent_count >= DRAIN_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (tracker.pending() > 0) @(posedge clk);
				drained = 1'b1;
			end
			send_byte(b);
		end
		s_tvalid <= 1'b0;

		while (tracker.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
